>>> rtl/rbf_pkg.sv
// Package: shared constants and types for the RBF surface evaluator.
`timescale 1ns / 1ps
package rbf_pkg;
   localparam int MAX_CENTERS = 1024;
   localparam int ADDR_W      = $clog2(MAX_CENTERS);
   localparam int CNT_W       = $clog2(MAX_CENTERS + 1);
   localparam int NUM_W       = 11;
   localparam int IDX_W       = 10;
   localparam int Q_W         = 32;
   localparam int DIFF_W      = Q_W + 1;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int RAD_W       = SQ_W;
   localparam int ROOT_W      = 34;
   localparam int TRY_W       = 70;
   localparam int PROD_W      = Q_W + ROOT_W + 1;
   localparam int ACC_W       = 64;
   localparam int VAL_W       = 48;
   localparam int REQ_DATA_W  = 144;
   localparam int CSR_IDX_W   = 3;
   localparam int ENTRY_W     = 4 * Q_W;

   localparam logic [ACC_W-1:0] VAL_MAX = ACC_W'({1'b0, {(VAL_W-1){1'b1}}});
   localparam logic [ACC_W-1:0] VAL_MIN = ~VAL_MAX;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NUM_CENTERS = 3'd0,
      REG_CONST_TERM  = 3'd1,
      REG_LIN_X       = 3'd2,
      REG_LIN_Y       = 3'd3,
      REG_LIN_Z       = 3'd4
   } csr_reg_type;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_RUN    = 2'd1,
      ST_DRAIN  = 2'd2,
      ST_FINISH = 2'd3
   } state_type;
endpackage

>>> rtl/rbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/rbf_implicit_surface_evaluator.sv
// Top level: RBF interpolant evaluator with center store and distance pipeline.
// Loads: a load is written in the cycle it is accepted; a query reads
//   n = min(num_centers, 1024) centers and returns one result when all terms drain.
// Throughput: one center term per cycle from the center RAM read port;
//   one query in flight at a time.
// Reset: synchronous, active high; clears config, state, counter and all valid
//   bits. The center store is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps
module rbf_implicit_surface_evaluator (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: index[9:0], pos_x[41:10], pos_y[73:42], pos_z[105:74],
   //        weight[137:106], zero fill
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rbf_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: command[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: value[47:0]
   output logic [rbf_pkg::VAL_W-1:0]       rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rbf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbf_pkg::Q_W-1:0]         csr_data
);
   import rbf_pkg::*;

   state_type state_ff, state_in;

   logic [NUM_W-1:0]  num_ff;
   logic signed [Q_W-1:0] const_ff, lin_x_ff, lin_y_ff, lin_z_ff;

   logic signed [Q_W-1:0] qx_ff, qy_ff, qz_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  n_lim;
   logic              rd_issue;

   logic [IDX_W-1:0]  req_index;
   logic [Q_W-1:0]    req_x, req_y, req_z, req_w;
   logic              req_fire, load_we, query_go;

   logic [ENTRY_W-1:0] rd_data;

   // pipeline
   logic                   v1_ff, v2_ff, v3_ff, v4_ff, vp_ff;
   logic [DIFF_W-1:0]      dx_ff, dy_ff, dz_ff;
   logic signed [Q_W-1:0]  w2_ff, w3_ff, w4_ff, wp_ff;
   logic [SQ_W-1:0]        sx_ff, sy_ff, sz_ff;
   logic [RAD_W-1:0]       sq_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]      sq_root_ff [ROOT_W+1];
   logic signed [Q_W-1:0]  sq_w_ff    [ROOT_W+1];
   logic [ROOT_W:0]        sq_v_ff;
   logic [RAD_W-1:0]       sq_rem_in  [ROOT_W];
   logic [ROOT_W-1:0]      sq_root_in [ROOT_W];
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic signed [2*Q_W-1:0]  px_ff, py_ff, pz_ff;
   logic signed [ACC_W-1:0]  poly_ff;
   logic signed [ACC_W-1:0]  total;
   logic                     pipe_busy;

   logic                  rsp_valid_ff;
   logic [VAL_W-1:0]      rsp_data_ff;

   logic signed [DIFF_W-1:0] ddx, ddy, ddz;

   assign req_index = req_tdata[IDX_W-1:0];
   assign req_x     = req_tdata[IDX_W +: Q_W];
   assign req_y     = req_tdata[IDX_W+Q_W +: Q_W];
   assign req_z     = req_tdata[IDX_W+2*Q_W +: Q_W];
   assign req_w     = req_tdata[IDX_W+3*Q_W +: Q_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_we    = req_fire && (req_tuser == CMD_LOAD)
                       && ({1'b0, req_index} < (IDX_W+1)'(MAX_CENTERS));
   assign query_go   = req_fire && (req_tuser == CMD_EVAL);
   assign csr_ready  = 1'b1;

   assign n_lim    = (num_ff > NUM_W'(MAX_CENTERS)) ? CNT_W'(MAX_CENTERS)
                                                     : CNT_W'(num_ff);
   assign rd_issue = (state_ff == ST_RUN) && (cnt_ff < n_lim);
   assign pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff || (|sq_v_ff) || vp_ff;

   rbf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CENTERS)) u_store (
      .clock (clock),
      .we    (load_we),
      .waddr (ADDR_W'(req_index)),
      .wdata ({req_w, req_z, req_y, req_x}),
      .raddr (cnt_ff[ADDR_W-1:0]),
      .rdata (rd_data)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff   <= '0;
         const_ff <= '0;
         lin_x_ff <= '0;
         lin_y_ff <= '0;
         lin_z_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_NUM_CENTERS: num_ff   <= csr_data[NUM_W-1:0];
            REG_CONST_TERM:  const_ff <= csr_data;
            REG_LIN_X:       lin_x_ff <= csr_data;
            REG_LIN_Y:       lin_y_ff <= csr_data;
            REG_LIN_Z:       lin_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (rd_issue) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // query point and polynomial part
   always_ff @(posedge clock) begin
      if (query_go) begin
         qx_ff <= req_x;
         qy_ff <= req_y;
         qz_ff <= req_z;
      end
      px_ff   <= lin_x_ff * qx_ff;
      py_ff   <= lin_y_ff * qy_ff;
      pz_ff   <= lin_z_ff * qz_ff;
      // arithmetic shift floors toward minus infinity
      poly_ff <= ACC_W'(const_ff) + (px_ff >>> 16) + (py_ff >>> 16) + (pz_ff >>> 16);
   end

   // difference stage
   assign ddx = DIFF_W'(qx_ff) - DIFF_W'($signed(rd_data[0 +: Q_W]));
   assign ddy = DIFF_W'(qy_ff) - DIFF_W'($signed(rd_data[Q_W +: Q_W]));
   assign ddz = DIFF_W'(qz_ff) - DIFF_W'($signed(rd_data[2*Q_W +: Q_W]));

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         sq_v_ff <= '0;
         vp_ff   <= 1'b0;
      end else begin
         v1_ff   <= rd_issue;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         sq_v_ff <= {sq_v_ff[ROOT_W-1:0], v4_ff};
         // product valid follows the last root stage, whose valid sits in sq_v_ff[ROOT_W-1]
         vp_ff   <= sq_v_ff[ROOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= ddx[DIFF_W-1] ? DIFF_W'(-ddx) : DIFF_W'(ddx);
      dy_ff <= ddy[DIFF_W-1] ? DIFF_W'(-ddy) : DIFF_W'(ddy);
      dz_ff <= ddz[DIFF_W-1] ? DIFF_W'(-ddz) : DIFF_W'(ddz);
      w2_ff <= rd_data[3*Q_W +: Q_W];
      sx_ff <= dx_ff * dx_ff;
      sy_ff <= dy_ff * dy_ff;
      sz_ff <= dz_ff * dz_ff;
      w3_ff <= w2_ff;
      sq_rem_ff[0]  <= sx_ff + sy_ff + sz_ff;
      sq_root_ff[0] <= '0;
      sq_w_ff[0]    <= w3_ff;
      w4_ff <= sq_w_ff[ROOT_W];
      for (int k = 0; k < ROOT_W; k++) begin
         sq_rem_ff[k+1]  <= sq_rem_in[k];
         sq_root_ff[k+1] <= sq_root_in[k];
         sq_w_ff[k+1]    <= sq_w_ff[k];
      end
      wp_ff   <= w4_ff;
      prod_ff <= sq_w_ff[ROOT_W] * $signed({1'b0, sq_root_ff[ROOT_W]});
   end

   // one root bit per stage, most significant first
   always_comb begin
      for (int k = 0; k < ROOT_W; k++) begin
         logic [TRY_W-1:0] trial;
         trial = (TRY_W'(sq_root_ff[k]) << (ROOT_W - k))
                 + (TRY_W'(1) << (2 * (ROOT_W - 1 - k)));
         if (TRY_W'(sq_rem_ff[k]) >= trial) begin
            sq_rem_in[k]  = sq_rem_ff[k] - RAD_W'(trial);
            sq_root_in[k] = sq_root_ff[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
         end else begin
            sq_rem_in[k]  = sq_rem_ff[k];
            sq_root_in[k] = sq_root_ff[k];
         end
      end
   end

   // accumulate floored terms
   always_ff @(posedge clock) begin
      if (query_go) begin
         acc_ff <= '0;
      end else if (vp_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff >>> 16);
      end
   end

   assign total = acc_ff + poly_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_tready)) begin
         if (total > $signed(VAL_MAX)) begin
            rsp_data_ff <= VAL_MAX[VAL_W-1:0];
         end else if (total < $signed(VAL_MIN)) begin
            rsp_data_ff <= VAL_MIN[VAL_W-1:0];
         end else begin
            rsp_data_ff <= total[VAL_W-1:0];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // wp_ff copies the last root stage weight via w4_ff; the product uses that weight directly
   a_wp_align: assert property (@(posedge clock) disable iff (reset)
      vp_ff |-> (wp_ff == $past(sq_w_ff[ROOT_W], 2)))
      else $error("weight pipeline misaligned");
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      rd_issue |-> (cnt_ff < CNT_W'(MAX_CENTERS)))
      else $error("read issued past store depth");
   a_finish_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !pipe_busy)
      else $error("result formed with terms in flight");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pipe_busy)
      else $error("pipeline busy while idle");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");
endmodule

>>> sim/tb_top.sv
// Testbench for rbf_implicit_surface_evaluator: checks query results against a predictor.
`timescale 1ns / 1ps
module tb_top;
   import rbf_pkg::*;

   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  SETTLE      = 1100;

   typedef struct packed {
      logic              cmd;
      logic [IDX_W-1:0]  idx;
      logic [Q_W-1:0]    x;
      logic [Q_W-1:0]    y;
      logic [Q_W-1:0]    z;
      logic [Q_W-1:0]    w;
   } center_req_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [VAL_W-1:0]      rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [Q_W-1:0]        csr_data;

   center_req_type    pending_reqs[$];
   logic [VAL_W-1:0]  expected_values[$];
   bit                loaded[MAX_CENTERS];
   bit                no_idle;
   int                errors = 0;
   int                cycles = 0;
   int                send_gap = 0;
   int                recv_stall = 0;

   // shadow of the block's state, updated on accepted transactions
   logic signed [Q_W-1:0] ctr_x[MAX_CENTERS];
   logic signed [Q_W-1:0] ctr_y[MAX_CENTERS];
   logic signed [Q_W-1:0] ctr_z[MAX_CENTERS];
   logic signed [Q_W-1:0] ctr_w[MAX_CENTERS];
   logic [NUM_W-1:0]      sh_count = '0;
   logic signed [Q_W-1:0] sh_const = '0, sh_lx = '0, sh_ly = '0, sh_lz = '0;

   rbf_implicit_surface_evaluator u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [33:0] floor_root(logic [127:0] v);
      logic [127:0] r, t;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         t = r | (128'd1 << b);
         if (t * t <= v) r = t;
      end
      return r[33:0];
   endfunction

   // floor of a*b / 2^16 with both operands signed
   function automatic logic signed [95:0] scaled_prod(logic signed [95:0] a,
                                                      logic signed [95:0] b);
      logic signed [95:0] p;
      p = a * b;
      return p >>> 16;
   endfunction

   function automatic logic [VAL_W-1:0] interpolant(logic signed [Q_W-1:0] px,
                                                    logic signed [Q_W-1:0] py,
                                                    logic signed [Q_W-1:0] pz);
      logic signed [95:0] acc, dx, dy, dz, wv, dv;
      logic [127:0]       sq;
      int                 n;
      acc = '0;
      n = (sh_count > MAX_CENTERS) ? MAX_CENTERS : int'(sh_count);
      for (int i = 0; i < n; i++) begin
         dx = px; dx = dx - ctr_x[i];
         dy = py; dy = dy - ctr_y[i];
         dz = pz; dz = dz - ctr_z[i];
         sq = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
         wv = ctr_w[i];
         dv = {62'b0, floor_root(sq)};
         acc = acc + scaled_prod(wv, dv);
      end
      acc = acc + sh_const;
      acc = acc + scaled_prod(sh_lx, px) + scaled_prod(sh_ly, py) + scaled_prod(sh_lz, pz);
      if (acc > 96'sh7FFF_FFFF_FFFF) acc = 96'sh7FFF_FFFF_FFFF;
      if (acc < -96'sh8000_0000_0000) acc = -96'sh8000_0000_0000;
      return acc[VAL_W-1:0];
   endfunction

   function automatic logic [Q_W-1:0] pick_q16();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic push_load(int idx, logic [Q_W-1:0] x, logic [Q_W-1:0] y,
                            logic [Q_W-1:0] z, logic [Q_W-1:0] w);
      pending_reqs.push_back('{CMD_LOAD, IDX_W'(idx), x, y, z, w});
      loaded[idx] = 1'b1;
   endtask

   task automatic push_query(logic [Q_W-1:0] x, logic [Q_W-1:0] y, logic [Q_W-1:0] z);
      pending_reqs.push_back('{CMD_EVAL, IDX_W'($urandom), x, y, z, $urandom});
   endtask

   task automatic cfg_write(csr_reg_type idx, logic [Q_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // drain all traffic, then let any work without a result finish
   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_values.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_poly(logic [Q_W-1:0] c, logic [Q_W-1:0] lx,
                           logic [Q_W-1:0] ly, logic [Q_W-1:0] lz);
      cfg_write(REG_CONST_TERM, c);
      cfg_write(REG_LIN_X, lx);
      cfg_write(REG_LIN_Y, ly);
      cfg_write(REG_LIN_Z, lz);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() != 0 && !no_idle && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 12) - 1;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            center_req_type r;
            r = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= r.cmd;
            req_tdata  <= {6'b0, r.w, r.z, r.y, r.x, r.idx};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(posedge clock) begin
      if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
         recv_stall = $urandom_range(1, 12) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: track config and loads, predict queries, check results
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_reg_type'(csr_index))
               REG_NUM_CENTERS: sh_count = csr_data[NUM_W-1:0];
               REG_CONST_TERM:  sh_const = csr_data;
               REG_LIN_X:       sh_lx = csr_data;
               REG_LIN_Y:       sh_ly = csr_data;
               REG_LIN_Z:       sh_lz = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_LOAD) begin
               ctr_x[req_tdata[9:0]] = req_tdata[41:10];
               ctr_y[req_tdata[9:0]] = req_tdata[73:42];
               ctr_z[req_tdata[9:0]] = req_tdata[105:74];
               ctr_w[req_tdata[9:0]] = req_tdata[137:106];
            end else begin
               expected_values.push_back(interpolant(req_tdata[41:10], req_tdata[73:42],
                                                     req_tdata[105:74]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_values.size() == 0) begin
               report_mismatch($sformatf("unexpected value %h", rsp_tdata));
            end else begin
               logic [VAL_W-1:0] want;
               want = expected_values.pop_front();
               if (rsp_tdata !== want)
                  report_mismatch($sformatf("value got %h want %h", rsp_tdata, want));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int n;
      reset = 1'b1;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      no_idle = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme centers and points, zero count, top slot
      cfg_write(REG_NUM_CENTERS, 32'd4);
      set_poly(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
      push_load(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_load(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_load(2, 32'h0, 32'h0, 32'h0, 32'h0);
      push_load(3, 32'h0001_8000, 32'hFFFF_0000, 32'h1234_5678, 32'hFFFF_FFFF);
      push_load(1023, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000);
      push_query(32'h0, 32'h0, 32'h0);
      push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      push_query(32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_8000);
      wait_idle();
      cfg_write(REG_NUM_CENTERS, 32'd0);
      set_poly(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      push_query(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      push_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      push_query(32'h0, 32'h0, 32'h0);

      // random phases, mostly small center counts
      for (int p = 0; p < 6; p++) begin
         wait_idle();
         n = (p == 3) ? $urandom_range(64, 128) : $urandom_range(1, 16);
         cfg_write(REG_NUM_CENTERS, n);
         set_poly(pick_q16(), pick_q16(), pick_q16(), pick_q16());
         for (int i = 0; i < n; i++)
            if (!loaded[i] || $urandom_range(0, 1))
               push_load(i, pick_q16(), pick_q16(), pick_q16(), pick_q16());
         for (int k = 0; k < 60; k++) begin
            // once, in phase p == 2, hold off until every outstanding result has come back
            if (p == 2 && k == 40)
               wait (pending_reqs.size() == 0 && !req_tvalid && expected_values.size() == 0);
            if ($urandom_range(0, 9) < 6)
               push_query(pick_q16(), pick_q16(), pick_q16());
            else
               push_load($urandom_range(0, MAX_CENTERS - 1), pick_q16(), pick_q16(),
                         pick_q16(), pick_q16());
         end
      end

      // back-to-back traffic, no idling
      wait_idle();
      no_idle = 1'b1;
      cfg_write(REG_NUM_CENTERS, 32'd24);
      set_poly(pick_q16(), pick_q16(), pick_q16(), pick_q16());
      for (int i = 0; i < 24; i++)
         if (!loaded[i])
            push_load(i, pick_q16(), pick_q16(), pick_q16(), pick_q16());
      for (int k = 0; k < 40; k++) begin
         if ($urandom_range(0, 9) < 6)
            push_query(pick_q16(), pick_q16(), pick_q16());
         else
            push_load($urandom_range(0, MAX_CENTERS - 1), pick_q16(), pick_q16(),
                      pick_q16(), pick_q16());
      end

      wait (pending_reqs.size() == 0 && !req_tvalid && expected_values.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

>>> filelist.f
rtl/rbf_pkg.sv
rtl/rbf_ram.sv
rtl/rbf_implicit_surface_evaluator.sv
sim/tb_top.sv
